// File: sv/knnwad_pkg.sv
// Shared types and constants for the k-NN window anomaly detector.
// Depends on nothing; every other file of the block imports it.
package knnwad_pkg;

  // Field widths fixed by the block's register and stream formats.
  localparam int SAMPLE_W  = 8;
  localparam int REF_BYTES = 5;
  localparam int REF_W     = SAMPLE_W * REF_BYTES;
  localparam int SCORE_W   = 19;
  localparam int THR_W     = 19;

  // Number of reference vector registers in the register map.
  localparam int REF_COUNT_MAX = 5;

  // Configuration register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = REF_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_REF_VECTOR_0 = 3'd0;
  localparam cfg_idx_t CFG_THRESHOLD_SQ = 3'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [REF_W-1:0]           ref_vec_t;
  typedef logic [SCORE_W-1:0]         score_t;
  typedef logic [THR_W-1:0]           thr_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // Register values after reset.
  localparam ref_vec_t REF_RESET [REF_COUNT_MAX] = '{
    40'd707120112548, 40'd707120112804, 40'd707136889764,
    40'd707136824483, 40'd707120112548
  };
  localparam thr_t THR_RESET = 19'd1;

endpackage

// File: sv/knnwad_ifs.sv
// Valid/ready channel interfaces of the k-NN window anomaly detector.
// Depends on knnwad_pkg for the payload types.

// Sample stream: one signed sample per request.
interface knnwad_sample_if;
  import knnwad_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Result stream: nearest-reference score and anomaly flag.
interface knnwad_result_if;
  import knnwad_pkg::*;
  logic   valid;
  logic   ready;
  score_t score_sq;
  logic   anomaly;
  modport source (output valid, output score_sq, output anomaly, input ready);
  modport sink (input valid, input score_sq, input anomaly, output ready);
endinterface

// Register write channel: register index and write data.
interface knnwad_cfg_if;
  import knnwad_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/knnwad_dist.sv
// Squared Euclidean distance from the sample window to one reference vector.
// Depends on knnwad_pkg; purely combinational, instanced once per reference.
module knnwad_dist
  import knnwad_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  sample_t  window [WINDOW_LEN],
  input  ref_vec_t ref_vec,
  output score_t   dist_sq
);

  logic [2*SAMPLE_W:0] sq [WINDOW_LEN];

  // One independent squarer per window slot. Slots beyond the reference
  // bytes are compared against zero.
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_feat
    logic signed [SAMPLE_W:0]     ref_ext;
    logic signed [SAMPLE_W:0]     diff;
    logic signed [2*SAMPLE_W+1:0] prod;
    if (i < REF_BYTES) begin : g_ref
      assign ref_ext = {ref_vec[SAMPLE_W*i+SAMPLE_W-1], ref_vec[SAMPLE_W*i +: SAMPLE_W]};
    end else begin : g_zero
      assign ref_ext = '0;
    end
    assign diff  = {window[i][SAMPLE_W-1], window[i]} - ref_ext;
    assign prod  = diff * diff;
    assign sq[i] = prod[2*SAMPLE_W:0];
  end

  // Sum of WINDOW_LEN squares; the total fits the score width for WINDOW_LEN up to eight.
  always_comb begin
    dist_sq = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      dist_sq = dist_sq + SCORE_W'(sq[i]);
    end
  end

endmodule

// File: sv/knn_window_anomaly_detector_unit.sv
// Top level of the k-NN window anomaly detector.
// Depends on knnwad_pkg, the channel interfaces and knnwad_dist.

// The block takes one signed sample per request into a circular window of
// WINDOW_LEN slots and, once every slot has been written, returns for each
// sample the minimum squared distance from the window (in slot order) to
// NUM_REFS reference vectors, with an anomaly flag when that minimum exceeds
// threshold_sq. Samples are taken one per clock cycle while results are not
// stalled; each sample is registered in the window and its result is then
// offered from the output register. The window register set is the input
// stage, all distance units and the minimum work combinationally in parallel
// behind it, and an output register holds the result, so a stalled result
// holds back new samples only once the window stage also holds a result. The
// first WINDOW_LEN-1 samples after reset produce no result. Register writes
// are always taken; writes to indexes beyond threshold_sq are ignored.
module knn_window_anomaly_detector_unit
  import knnwad_pkg::*;
#(
  parameter int WINDOW_LEN = 5,
  parameter int NUM_REFS   = 5
) (
  input  logic            clk,
  input  logic            rst,
  knnwad_sample_if.sink   samples,
  knnwad_result_if.source results,
  knnwad_cfg_if.sink      cfg
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  sample_t           window [WINDOW_LEN];
  logic [SLOT_W-1:0] write_slot;
  logic              window_full;
  logic              calc_valid;
  ref_vec_t          ref_vectors [REF_COUNT_MAX];
  thr_t              threshold_sq;
  score_t            ref_dist [NUM_REFS];
  score_t            best;
  logic              out_valid;
  score_t            out_score;
  logic              out_anomaly;
  logic              advance;
  logic              accept;

  // Handshake: the window stage moves on when the output register is free.
  assign advance       = calc_valid && (!out_valid || results.ready);
  assign samples.ready = !calc_valid || advance;
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REF_COUNT_MAX; k++) begin
        ref_vectors[k] <= REF_RESET[k];
      end
      threshold_sq <= THR_RESET;
    end else if (cfg.valid) begin
      for (int k = 0; k < REF_COUNT_MAX; k++) begin
        if (cfg.index == CFG_REF_VECTOR_0 + cfg_idx_t'(k)) begin
          ref_vectors[k] <= cfg.data;
        end
      end
      if (cfg.index == CFG_THRESHOLD_SQ) begin
        threshold_sq <= cfg.data[THR_W-1:0];
      end
    end
  end

  // Window slots: each slot loads the sample when the write pointer is on it.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (write_slot == SLOT_W'(i)) begin
          window[i] <= samples.sample;
        end
      end
    end
  end

  // Write pointer, fill flag and window stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      window_full <= 1'b0;
      calc_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (write_slot == LAST_SLOT) begin
          write_slot  <= '0;
          window_full <= 1'b1;
          calc_valid  <= 1'b1;
        end else begin
          write_slot <= write_slot + 1'b1;
          calc_valid <= window_full;
        end
      end else if (advance) begin
        calc_valid <= 1'b0;
      end
    end
  end

  // One distance unit per reference vector.
  for (genvar k = 0; k < NUM_REFS; k++) begin : g_ref
    knnwad_dist #(
      .WINDOW_LEN (WINDOW_LEN)
    ) u_dist (
      .window  (window),
      .ref_vec (ref_vectors[k]),
      .dist_sq (ref_dist[k])
    );
  end

  // Minimum over the references; ties keep the lower-numbered one.
  always_comb begin
    best = ref_dist[0];
    for (int k = 1; k < NUM_REFS; k++) begin
      if (ref_dist[k] < best) begin
        best = ref_dist[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_score   <= best;
      out_anomaly <= (best > threshold_sq);
    end
  end

  assign results.valid    = out_valid;
  assign results.score_sq = out_score;
  assign results.anomaly  = out_anomaly;

endmodule

// File: sv/knnwad_checker.sv
// Port-level checks for the k-NN window anomaly detector, with its bind.
// Depends on knnwad_pkg and on the top level knn_window_anomaly_detector_unit.
module knnwad_checker
  import knnwad_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input logic   clk,
  input logic   rst,
  input logic   samples_valid,
  input logic   samples_ready,
  input logic   results_valid,
  input logic   results_ready,
  input score_t results_score_sq,
  input logic   results_anomaly,
  input logic   cfg_ready
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic [CNT_W-1:0] accepted;
  logic             sample_req;

  assign sample_req = samples_valid && samples_ready;

  // Samples accepted since reset, saturating at the window length.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted <= '0;
    end else if (sample_req && (accepted != CNT_W'(WINDOW_LEN))) begin
      accepted <= accepted + 1'b1;
    end
  end

  // No result until the window has been filled once.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    results_valid |-> (accepted == CNT_W'(WINDOW_LEN)))
    else $error("result before the window was filled");

  // A fresh result follows an accepted sample through the window stage and the output register.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(results_valid) |-> $past(sample_req, 2))
    else $error("result without a matching sample request");

  // An anomaly needs a score above the threshold, which is never below zero.
  a_anomaly_score: assert property (@(posedge clk) disable iff (rst)
    (results_valid && results_anomaly) |-> (results_score_sq != '0))
    else $error("anomaly flagged with a zero score");

  // A stalled result holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (results_valid && !results_ready) |=>
      (results_valid && $stable(results_score_sq) && $stable(results_anomaly)))
    else $error("stalled result changed");

  // Register writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register write port not ready");

endmodule

bind knn_window_anomaly_detector_unit knnwad_checker #(
  .WINDOW_LEN (WINDOW_LEN)
) u_checker (
  .clk              (clk),
  .rst              (rst),
  .samples_valid    (samples.valid),
  .samples_ready    (samples.ready),
  .results_valid    (results.valid),
  .results_ready    (results.ready),
  .results_score_sq (results.score_sq),
  .results_anomaly  (results.anomaly),
  .cfg_ready        (cfg.ready)
);
